@@ sv/u8sd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned CNT_W = 3;

  localparam logic [CP_W-1:0] SUBST_CHAR = CP_W'(8'h3f);

  // one raw byte of the stream
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_item_t;

  // one decoded result
  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic             substituted;
    logic [CNT_W-1:0] byte_count;
    logic             last_of_run;
  } out_item_t;

  // all results caused by one byte: leading '?'s, an optional main result,
  // then trailing '?'s from an end-of-text flush
  typedef struct packed {
    logic [1:0]       pre_subst;
    logic             has_main;
    logic [CP_W-1:0]  main_cp;
    logic             main_sub;
    logic [CNT_W-1:0] main_cnt;
    logic [1:0]       post_subst;
  } run_t;

  function automatic logic [CNT_W-1:0] run_len(input run_t r);
    run_len = CNT_W'(r.pre_subst) + CNT_W'(r.has_main) + CNT_W'(r.post_subst);
  endfunction

endpackage

@@ sv/utf8_stream_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// UTF-8 byte stream to code point decoder with '?' substitution.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the two-entry run buffer has room; each
// byte is decoded in the cycle it is taken and yields zero to four results,
// which leave one per cycle while out_stall is low, so throughput is one byte
// per cycle whenever a byte averages at most one result and the output is not
// stalled. A byte that only opens or extends a sequence produces nothing. A
// byte's results are registered in the run buffer before they leave. Malformed
// or flushed bytes come out as code point 0x3F with substituted set, one result
// per byte covered; last_of_run marks the final result of each byte.
module utf8_stream_decoder_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  u8sd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output u8sd_pkg::out_item_t out_data
);
  import u8sd_pkg::*;

  run_t run;
  logic run_nonempty, take, full;

  assign in_stall = full;
  assign take     = in_valid && !full;

  u8sd_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .item         (in_data),
    .run          (run),
    .run_nonempty (run_nonempty)
  );

  u8sd_expand u_expand (
    .clk       (clk),
    .rst       (rst),
    .push      (take && run_nonempty),
    .run_in    (run),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_data)
  );

  // a substitution always stands for a single byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.substituted |->
      out_data.code_point == SUBST_CHAR && out_data.byte_count == CNT_W'(1))
    else $error("substitution with wrong payload");

  // decoded results cover one to four bytes
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.byte_count != '0 && out_data.byte_count <= CNT_W'(4))
    else $error("byte count out of range");

  // nothing is pending right after reset
  assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid && !in_stall)
    else $error("output pending after reset");

endmodule

@@ sv/u8sd_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_decode
// Sequence state and per-byte decode into a run of results.
// ----------------------------------------------------------------------------
module u8sd_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  u8sd_pkg::in_item_t item,
  output u8sd_pkg::run_t    run,
  output logic              run_nonempty
);
  import u8sd_pkg::*;

  logic [2:0]      expected_length, expected_length_next;
  logic [1:0]      bytes_collected, bytes_collected_next;
  logic [CP_W-1:0] partial_code, partial_code_next;

  logic [7:0] b;
  logic       cont;
  logic [2:0] coll_inc;

  assign b        = item.data_byte;
  assign cont     = (b[7:6] == 2'b10);
  assign coll_inc = {1'b0, bytes_collected} + 3'd1;

  always_comb begin
    expected_length_next = expected_length;
    bytes_collected_next = bytes_collected;
    partial_code_next    = partial_code;
    run                  = '0;
    if (expected_length != 3'd0 && cont) begin
      partial_code_next    = {partial_code[CP_W-7:0], b[5:0]};
      bytes_collected_next = coll_inc[1:0];
      if (coll_inc >= expected_length) begin
        run.has_main         = 1'b1;
        run.main_cp          = {partial_code[CP_W-7:0], b[5:0]};
        run.main_cnt         = expected_length;
        expected_length_next = 3'd0;
        bytes_collected_next = 2'd0;
        partial_code_next    = '0;
      end
    end else begin
      // an interrupted sequence gives one '?' per byte held
      if (expected_length != 3'd0) begin
        run.pre_subst = bytes_collected;
      end
      expected_length_next = 3'd0;
      bytes_collected_next = 2'd0;
      partial_code_next    = '0;
      if (!b[7]) begin
        run.has_main = 1'b1;
        run.main_cp  = CP_W'(b);
        run.main_cnt = 3'd1;
      end else if (b[7:5] == 3'b110) begin
        expected_length_next = 3'd2;
        bytes_collected_next = 2'd1;
        partial_code_next    = CP_W'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
        expected_length_next = 3'd3;
        bytes_collected_next = 2'd1;
        partial_code_next    = CP_W'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
        expected_length_next = 3'd4;
        bytes_collected_next = 2'd1;
        partial_code_next    = CP_W'(b[2:0]);
      end else begin
        run.has_main = 1'b1;
        run.main_cp  = SUBST_CHAR;
        run.main_sub = 1'b1;
        run.main_cnt = 3'd1;
      end
    end
    // end of text flushes whatever is still open
    if (item.end_of_text && expected_length_next != 3'd0) begin
      run.post_subst       = bytes_collected_next;
      expected_length_next = 3'd0;
      bytes_collected_next = 2'd0;
      partial_code_next    = '0;
    end
  end

  assign run_nonempty = (run_len(run) != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= 3'd0;
      bytes_collected <= 2'd0;
      partial_code    <= '0;
    end else if (take) begin
      expected_length <= expected_length_next;
      bytes_collected <= bytes_collected_next;
      partial_code    <= partial_code_next;
    end
  end

endmodule

@@ sv/u8sd_expand.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_expand
// Two-entry run buffer that plays each run out as single results.
// ----------------------------------------------------------------------------
module u8sd_expand (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  u8sd_pkg::run_t     run_in,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output u8sd_pkg::out_item_t out_item
);
  import u8sd_pkg::*;

  run_t             entries [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count, count_next;
  logic [CNT_W-1:0] idx;

  run_t             head;
  logic [CNT_W-1:0] head_len;
  logic             is_last, pop, xfer;

  assign head      = entries[rd_ptr];
  assign head_len  = run_len(head);
  assign is_last   = (idx == head_len - CNT_W'(1));
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign xfer      = out_valid && !out_stall;
  assign pop       = xfer && is_last;

  always_comb begin
    out_item             = '0;
    out_item.last_of_run = is_last;
    if (head.has_main && idx == CNT_W'(head.pre_subst)) begin
      out_item.code_point  = head.main_cp;
      out_item.substituted = head.main_sub;
      out_item.byte_count  = head.main_cnt;
    end else begin
      out_item.code_point  = SUBST_CHAR;
      out_item.substituted = 1'b1;
      out_item.byte_count  = CNT_W'(1);
    end
  end

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= run_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
      idx    <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
        idx    <= '0;
      end else if (xfer) begin
        idx <= idx + CNT_W'(1);
      end
    end
  end

endmodule
